// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker of this block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge while reset is low.
`define DTU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define DTU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/dtu_pkg.sv =====
// Types, codes and calendar helpers for the datetime to UTC normalizer.
// No dependencies; used by the converter, the top level and the checker.
package dtu_pkg;

  // Date kinds on the input tuser.
  localparam logic [1:0] KIND_CALENDAR = 2'd0;
  localparam logic [1:0] KIND_ORDINAL  = 2'd1;
  localparam logic [1:0] KIND_WEEK     = 2'd2;

  // Status codes on the output tuser.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_WEEK_DATE = 2'd1;
  localparam logic [1:0] STATUS_NO_DATE   = 2'd2;
  localparam logic [1:0] STATUS_NO_TIME   = 2'd3;

  localparam logic [3:0] MONTH_JAN     = 4'd1;
  localparam logic [3:0] MONTH_FEB     = 4'd2;
  localparam logic [3:0] MONTH_DEC     = 4'd12;
  localparam logic [4:0] DAYS_LONG     = 5'd31;
  localparam logic [8:0] DAYS_YEAR     = 9'd365;
  localparam logic [8:0] DAYS_LEAP     = 9'd366;
  localparam logic signed [7:0] MINS_PER_HOUR = 8'sd60;
  localparam logic signed [7:0] HOURS_PER_DAY = 8'sd24;

  // year / 25 == (year * 5243) >> 17, exact for every 14-bit year.
  localparam int unsigned DIV25_MULT  = 5243;
  localparam int unsigned DIV25_SHIFT = 17;

  typedef struct packed {
    logic [5:0]        pad;
    logic [5:0]        zone_minutes;
    logic signed [5:0] zone_hours;
    logic              is_local;
    logic              minute_present;
    logic [5:0]        minute;
    logic [4:0]        hour;
    logic              date_complete;
    logic [8:0]        ordinal_day;
    logic [4:0]        day;
    logic [3:0]        month;
    logic [13:0]       year;
  } in_data_t;

  typedef struct packed {
    logic [3:0]         pad;
    logic [5:0]         utc_minute;
    logic [4:0]         utc_hour;
    logic [8:0]         utc_ordinal_day;
    logic [4:0]         utc_day;
    logic [3:0]         utc_month;
    logic signed [14:0] utc_year;
  } out_data_t;

  typedef struct packed {
    logic [1:0] status;
    out_data_t  data;
  } result_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      MONTH_FEB:               d = leap ? 5'd29 : 5'd28;
      default:                 d = DAYS_LONG;
    endcase
    return d;
  endfunction

  function automatic logic [8:0] year_days(input logic leap);
    return leap ? DAYS_LEAP : DAYS_YEAR;
  endfunction

endpackage

// ===== sv/dtu_convert.sv =====
// Combinational offset removal and one-day calendar step for one item.
// Depends on dtu_pkg for the item layouts, codes and month lengths.
module dtu_convert (
  input  logic [1:0]       kind,
  input  dtu_pkg::in_data_t din,
  output dtu_pkg::result_t  res
);

  logic              active;
  logic              time_err;
  logic signed [7:0] mins_a;
  logic signed [7:0] mins_b;
  logic signed [7:0] hr_a;
  logic signed [7:0] hr_b;
  logic signed [7:0] hr_c;
  logic              min_lo;
  logic              min_hi;
  logic              hr_back;
  logic              hr_fwd;
  logic              move_req;
  logic              day_back;
  logic              day_fwd;
  logic [1:0]        status;
  logic [26:0]       div_prod;
  logic [9:0]        div_q;
  logic [13:0]       div_rem;
  logic [4:0]        year_mod25;
  logic              leap_cur;
  logic              leap_prev;
  logic [4:0]        days_cur;
  logic [4:0]        days_prev;
  logic [14:0]       year_ext;
  logic [14:0]       year_dec;
  logic [14:0]       year_inc;
  logic [5:0]        day_inc;
  logic [4:0]        month_inc;
  logic [14:0]       y_o;
  logic [3:0]        m_o;
  logic [4:0]        d_o;
  logic [8:0]        yd_o;

  // Time of day: minute offset first with one carry or borrow, then the hour.
  always_comb begin
    active   = !din.is_local &&
               ((din.zone_hours != 6'sd0) || (din.zone_minutes != 6'd0));
    time_err = active && (din.zone_minutes != 6'd0) && !din.minute_present;
    if (din.zone_hours[5]) begin
      mins_a = $signed({2'b00, din.minute}) + $signed({2'b00, din.zone_minutes});
    end else begin
      mins_a = $signed({2'b00, din.minute}) - $signed({2'b00, din.zone_minutes});
    end
    hr_a   = $signed({3'b000, din.hour}) -
             $signed({{2{din.zone_hours[5]}}, din.zone_hours});
    min_lo = mins_a < 8'sd0;
    min_hi = mins_a >= dtu_pkg::MINS_PER_HOUR;
    if (min_lo) begin
      mins_b = mins_a + dtu_pkg::MINS_PER_HOUR;
      hr_b   = hr_a - 8'sd1;
    end else if (min_hi) begin
      mins_b = mins_a - dtu_pkg::MINS_PER_HOUR;
      hr_b   = hr_a + 8'sd1;
    end else begin
      mins_b = mins_a;
      hr_b   = hr_a;
    end
    hr_back = hr_b < 8'sd0;
    hr_fwd  = hr_b >= dtu_pkg::HOURS_PER_DAY;
    if (hr_back) begin
      hr_c = hr_b + dtu_pkg::HOURS_PER_DAY;
    end else if (hr_fwd) begin
      hr_c = hr_b - dtu_pkg::HOURS_PER_DAY;
    end else begin
      hr_c = hr_b;
    end
    move_req = active && !time_err && (hr_back || hr_fwd);
    priority if (time_err) begin
      status = dtu_pkg::STATUS_NO_TIME;
    end else if (move_req && kind[1]) begin
      status = dtu_pkg::STATUS_WEEK_DATE;
    end else if (move_req && !din.date_complete) begin
      status = dtu_pkg::STATUS_NO_DATE;
    end else begin
      status = dtu_pkg::STATUS_OK;
    end
    day_back = move_req && (status == dtu_pkg::STATUS_OK) && hr_back;
    day_fwd  = move_req && (status == dtu_pkg::STATUS_OK) && hr_fwd;
  end

  // Leap years need year mod 25; the previous year is leap when this year
  // is 1 mod 4 and, if it is 1 mod 25, also 1 mod 16.
  always_comb begin
    div_prod   = 27'(din.year) * 27'(dtu_pkg::DIV25_MULT);
    div_q      = 10'(div_prod >> dtu_pkg::DIV25_SHIFT);
    div_rem    = din.year - 14'({4'b0000, div_q} * 14'd25);
    year_mod25 = div_rem[4:0];
    leap_cur   = (din.year[1:0] == 2'd0) &&
                 ((year_mod25 != 5'd0) || (din.year[3:0] == 4'd0));
    leap_prev  = (din.year[1:0] == 2'd1) &&
                 ((year_mod25 != 5'd1) || (din.year[3:0] == 4'd1));
    days_cur   = dtu_pkg::month_days(din.month, leap_cur);
    days_prev  = dtu_pkg::month_days(din.month - 4'd1, leap_cur);
  end

  always_comb begin
    year_ext  = {1'b0, din.year};
    year_dec  = year_ext - 15'd1;
    year_inc  = year_ext + 15'd1;
    day_inc   = {1'b0, din.day} + 6'd1;
    month_inc = {1'b0, din.month} + 5'd1;
    y_o  = year_ext;
    m_o  = din.month;
    d_o  = din.day;
    yd_o = din.ordinal_day;
    if (day_back) begin
      if (kind == dtu_pkg::KIND_CALENDAR) begin
        if ((din.day <= 5'd1) && (din.month == dtu_pkg::MONTH_JAN)) begin
          d_o = dtu_pkg::DAYS_LONG;
          m_o = dtu_pkg::MONTH_DEC;
          y_o = year_dec;
        end else if ((din.day <= 5'd1) && (din.month >= dtu_pkg::MONTH_FEB) &&
                     (din.month <= dtu_pkg::MONTH_DEC)) begin
          m_o = din.month - 4'd1;
          d_o = days_prev;
        end else begin
          // A later day or an invalid month keeps month and year; the day just steps down.
          d_o = din.day - 5'd1;
        end
      end else if (din.ordinal_day == 9'd1) begin
        y_o  = year_dec;
        yd_o = dtu_pkg::year_days(leap_prev);
      end else begin
        yd_o = din.ordinal_day - 9'd1;
      end
    end else if (day_fwd) begin
      if (kind == dtu_pkg::KIND_CALENDAR) begin
        if (day_inc > {1'b0, days_cur}) begin
          d_o = 5'd1;
          if (month_inc > {1'b0, dtu_pkg::MONTH_DEC}) begin
            m_o = dtu_pkg::MONTH_JAN;
            y_o = year_inc;
          end else begin
            m_o = month_inc[3:0];
          end
        end else begin
          d_o = day_inc[4:0];
        end
      end else if (din.ordinal_day == dtu_pkg::year_days(leap_cur)) begin
        y_o  = year_inc;
        yd_o = 9'd1;
      end else begin
        yd_o = din.ordinal_day + 9'd1;
      end
    end
  end

  always_comb begin
    res        = '0;
    res.status = status;
    if (status == dtu_pkg::STATUS_OK) begin
      res.data.utc_year        = $signed(y_o);
      res.data.utc_month       = (kind == dtu_pkg::KIND_CALENDAR) ? m_o : 4'd0;
      res.data.utc_day         = (kind == dtu_pkg::KIND_CALENDAR) ? d_o : 5'd0;
      res.data.utc_ordinal_day = (kind == dtu_pkg::KIND_ORDINAL) ? yd_o : 9'd0;
      res.data.utc_hour        = active ? hr_c[4:0] : din.hour;
      res.data.utc_minute      = active ? mins_b[5:0] : din.minute;
    end
  end

endmodule

// ===== sv/datetime_to_utc_normalizer_unit.sv =====
// Top level of the datetime to UTC normalizer: stream ports and pipeline.
// Depends on dtu_pkg and dtu_convert.
// A result is registered in the input register and then in the result register before it shows.
// Throughput: one item per cycle while the output is ready, set by the input and result registers.
// The input stalls only while a result waits and the input register is also full.
// Reset (synchronous, active high) clears both valid flags; payload is not reset.
module datetime_to_utc_normalizer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // year[13:0], month[17:14], day[22:18], ordinal_day[31:23],
  // date_complete[32], hour[37:33], minute[43:38], minute_present[44],
  // is_local[45], zone_hours[51:46], zone_minutes[57:52], zero fill
  input  logic [63:0] s_axis_tdata,
  // date_kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // utc_year[14:0], utc_month[18:15], utc_day[23:19], utc_ordinal_day[32:24],
  // utc_hour[37:33], utc_minute[43:38], zero fill
  output logic [47:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);

  logic              in_valid;
  dtu_pkg::in_data_t in_data;
  logic [1:0]        in_kind;
  dtu_pkg::result_t  conv;
  logic              out_valid;
  dtu_pkg::result_t  out_res;
  logic              advance;

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data <= s_axis_tdata;
      in_kind <= s_axis_tuser;
    end
  end

  dtu_convert u_convert (
    .kind (in_kind),
    .din  (in_data),
    .res  (conv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      out_res <= conv;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.data;
  assign m_axis_tuser  = out_res.status;

endmodule

// ===== sv/dtu_checker.sv =====
// Port-level checks for the datetime to UTC normalizer, bound to the top level.
// Depends on dtu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dtu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A stalled result keeps its payload until the transfer.
  `DTU_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // Reset empties the pipeline.
  `DTU_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid, "result valid right after reset")

  // The input side stalls only behind a waiting result.
  `DTU_ASSERT(a_ready_rate, clk, rst, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled with room downstream")

  // An error result carries no date or time.
  `DTU_ASSERT(a_error_zero, clk, rst, m_axis_tvalid && (m_axis_tuser != dtu_pkg::STATUS_OK) |-> m_axis_tdata == 48'd0, "error result with nonzero fields")

  // Calendar and ordinal fields are never both in use.
  `DTU_ASSERT(a_one_form, clk, rst, m_axis_tvalid && (m_axis_tdata[18:15] != 4'd0) |-> m_axis_tdata[32:24] == 9'd0, "month and ordinal day both set")

endmodule

bind datetime_to_utc_normalizer_unit dtu_checker u_dtu_checker (.*);
